// ----- hdl/ssvs_pkg.sv -----
// ----------------------------------------------------------------------------
// ssvs_pkg
// Shared types, constants and functions of the seven-segment value scanner.
// ----------------------------------------------------------------------------
package ssvs_pkg;

  localparam int unsigned ValueW   = 16;
  localparam int unsigned BcdDigits = 5;
  localparam int unsigned BcdW     = 4 * BcdDigits;
  localparam int unsigned CntW     = $clog2(ValueW);
  localparam int unsigned SelW     = 3;
  localparam int unsigned SegW     = 8;
  localparam int unsigned ShowW    = 12;

  localparam logic [1:0] REQ_TICK      = 2'd0;
  localparam logic [1:0] REQ_INT       = 2'd1;
  localparam logic [1:0] REQ_FIX       = 2'd2;
  localparam logic [1:0] REQ_FIX_BLINK = 2'd3;

  localparam logic [SelW-1:0] SEL_NONE   = 3'd0;
  localparam logic [SelW-1:0] LEFT_BASE  = 3'd1;
  localparam logic [SelW-1:0] RIGHT_BASE = 3'd4;

  localparam logic [SegW-1:0] SEG_BLANK = 8'h00;
  localparam logic [SegW-1:0] SEG_POINT = 8'h80;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } ssvs_state_e;

  typedef struct packed {
    logic              start;
    logic [ValueW-1:0] value;
  } bcd_req_t;

  typedef struct packed {
    logic            done;
    logic [BcdW-1:0] digits;
  } bcd_res_t;

  // add-3 step of the shift-and-add conversion
  function automatic logic [3:0] dd_adjust(logic [3:0] d);
    dd_adjust = (d >= 4'd5) ? d + 4'd3 : d;
  endfunction

  function automatic logic [SegW-1:0] seg_of(logic [3:0] d);
    logic [SegW-1:0] s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = SEG_BLANK;
    endcase
    seg_of = s;
  endfunction

endpackage

// ----- hdl/ssvs_if.sv -----
// ----------------------------------------------------------------------------
// ssvs_if
// Request and scan result channels of the seven-segment value scanner.
// ----------------------------------------------------------------------------
interface ssvs_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic        right_side;
  logic [15:0] value;

  modport source (output valid, output req_type, output right_side, output value,
                  input ready);
  modport sink (input valid, input req_type, input right_side, input value,
                output ready);
endinterface

interface ssvs_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] digit_select;
  logic [7:0] segments;
  logic       last;

  modport source (output valid, output digit_select, output segments, output last,
                  input ready);
  modport sink (input valid, input digit_select, input segments, input last,
                output ready);
endinterface

// ----- hdl/seven_segment_value_scanner_top.sv -----
// ----------------------------------------------------------------------------
// seven_segment_value_scanner_top
// Drives either three-digit half of a six-digit seven-segment display, per request.
// ----------------------------------------------------------------------------
// in_i takes requests (valid/ready): req_type, right_side and a 16-bit value.
// out_o returns scan results (valid/ready): digit_select, segments and last,
// with last set on the final result of each request.
// A blink tick toggles the blink flag and gives no result.
// Other requests run through a bit-serial binary to BCD converter that shifts
// one value bit per cycle; once it is done, the first result is loaded into
// the output register. Results then follow one per cycle while out_o is
// ready: three, or four for a fixed-point value below 1000. One request is
// in work at a time, through the 16-step conversion and the scan; an integer
// request of 1000 or more gives no result while no integer digits are held.
// in_i ready drops while a request is converted or scanned; it rises again
// once the final result is in the output register, even if that result still
// waits for the receiver. A stalled receiver holds the output register and
// halts the scan. Reset clears the blink flag (blinking digits hidden) and
// forgets the digits last shown by an integer request.
// ----------------------------------------------------------------------------
module seven_segment_value_scanner_top import ssvs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ssvs_req_if.sink   in_i,
  ssvs_res_if.source out_o
);

  bcd_req_t bcd_req;
  bcd_res_t bcd_res;

  ssvs_bcd u_bcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (bcd_req),
    .res_o  (bcd_res)
  );

  ssvs_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .out_o     (out_o),
    .bcd_req_o (bcd_req),
    .bcd_res_i (bcd_res)
  );

endmodule

// ----- hdl/ssvs_bcd.sv -----
// ----------------------------------------------------------------------------
// ssvs_bcd
// Bit-serial binary to BCD converter, one value bit per cycle (shift and add 3).
// ----------------------------------------------------------------------------
module ssvs_bcd import ssvs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  bcd_req_t req_i,
  output bcd_res_t res_o
);

  logic [ValueW-1:0] bin_q, bin_d;
  logic [BcdW-1:0]   bcd_q, bcd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [BcdW-1:0]   adj;

  always_comb begin
    for (int i = 0; i < BcdDigits; i++) begin
      adj[4*i +: 4] = dd_adjust(bcd_q[4*i +: 4]);
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      bin_d  = req_i.value;
      bcd_d  = '0;
      cnt_d  = CntW'(ValueW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d = {adj[BcdW-2:0], bin_q[ValueW-1]};
      bin_d = {bin_q[ValueW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign res_o.done   = done_q;
  assign res_o.digits = bcd_q;

endmodule

// ----- hdl/ssvs_seq.sv -----
// ----------------------------------------------------------------------------
// ssvs_seq
// Request sequencer: blink flag, held integer digits and the scan output register.
// ----------------------------------------------------------------------------
module ssvs_seq import ssvs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ssvs_req_if.sink    in_i,
  ssvs_res_if.source  out_o,
  output bcd_req_t    bcd_req_o,
  input  bcd_res_t    bcd_res_i
);

  ssvs_state_e      state_q, state_d;
  logic [1:0]       req_q, req_d;
  logic             side_q, side_d;
  logic             blink_q, blink_d;
  logic [ShowW-1:0] shown_q, shown_d;
  logic             shown_vld_q, shown_vld_d;
  logic [ShowW-1:0] dig_q, dig_d;
  logic             pt_q, pt_d;
  logic             hide_q, hide_d;
  logic [1:0]       idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  logic [SelW-1:0]  out_sel_q, out_sel_d;
  logic [SegW-1:0]  out_seg_q, out_seg_d;
  logic             out_last_q, out_last_d;

  logic             accept;
  logic             under_k;
  logic             load;
  logic [1:0]       off;
  logic [3:0]       cur_dig;
  logic             cur_point;
  logic             cur_last;
  logic [SelW-1:0]  base;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  assign bcd_req_o.start = accept && (in_i.req_type != REQ_TICK);
  assign bcd_req_o.value = in_i.value;

  // below 1000: ten-thousands and thousands digits are zero
  assign under_k = (bcd_res_i.digits[BcdW-1:ShowW] == '0);
  assign base    = side_q ? RIGHT_BASE : LEFT_BASE;

  // scan step selection
  always_comb begin
    off       = idx_q;
    cur_dig   = dig_q[11:8];
    cur_point = 1'b0;
    cur_last  = 1'b0;
    if (pt_q) begin
      case (idx_q)
        2'd0: begin
          off     = 2'd0;
          cur_dig = dig_q[11:8];
        end
        2'd1: begin
          off     = 2'd1;
          cur_dig = dig_q[7:4];
        end
        2'd2: begin
          off       = 2'd1;
          cur_point = 1'b1;
        end
        default: begin
          off      = 2'd2;
          cur_dig  = dig_q[3:0];
          cur_last = 1'b1;
        end
      endcase
    end else begin
      case (idx_q)
        2'd0:    cur_dig = dig_q[11:8];
        2'd1:    cur_dig = dig_q[7:4];
        default: begin
          cur_dig  = dig_q[3:0];
          cur_last = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    side_d      = side_q;
    blink_d     = blink_q;
    shown_d     = shown_q;
    shown_vld_d = shown_vld_q;
    dig_d       = dig_q;
    pt_d        = pt_q;
    hide_d      = hide_q;
    idx_d       = idx_q;
    load        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_i.req_type == REQ_TICK) begin
            blink_d = ~blink_q;
          end else begin
            req_d   = in_i.req_type;
            side_d  = in_i.right_side;
            state_d = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        if (bcd_res_i.done) begin
          hide_d  = (req_q == REQ_FIX_BLINK) && !blink_q;
          idx_d   = 2'd0;
          state_d = ST_EMIT;
          if (req_q == REQ_INT) begin
            pt_d = 1'b0;
            if (under_k) begin
              dig_d       = bcd_res_i.digits[ShowW-1:0];
              shown_d     = bcd_res_i.digits[ShowW-1:0];
              shown_vld_d = 1'b1;
            end else if (shown_vld_q) begin
              dig_d = shown_q;
            end else begin
              state_d = ST_IDLE;
            end
          end else begin
            pt_d  = under_k;
            dig_d = under_k ? bcd_res_i.digits[ShowW-1:0] : bcd_res_i.digits[ShowW+3:4];
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          load  = 1'b1;
          idx_d = idx_q + 2'd1;
          if (cur_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_sel_d   = out_sel_q;
    out_seg_d   = out_seg_q;
    out_last_d  = out_last_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_last_d  = cur_last;
      if (hide_q) begin
        out_sel_d = SEL_NONE;
        out_seg_d = SEG_BLANK;
      end else begin
        out_sel_d = base + {1'b0, off};
        out_seg_d = cur_point ? SEG_POINT : seg_of(cur_dig);
      end
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      blink_q     <= 1'b0;
      shown_q     <= '0;
      shown_vld_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      blink_q     <= blink_d;
      shown_q     <= shown_d;
      shown_vld_q <= shown_vld_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    side_q     <= side_d;
    dig_q      <= dig_d;
    pt_q       <= pt_d;
    hide_q     <= hide_d;
    out_sel_q  <= out_sel_d;
    out_seg_q  <= out_seg_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.digit_select = out_sel_q;
  assign out_o.segments     = out_seg_q;
  assign out_o.last         = out_last_q;

endmodule

// ----- hdl/ssvs_checker.sv -----
// ----------------------------------------------------------------------------
// ssvs_checker
// Port-level checks of the seven-segment value scanner, bound to the top level.
// ----------------------------------------------------------------------------
module ssvs_checker import ssvs_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_req_type_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] out_digit_select_i,
  input logic [7:0] out_segments_i,
  input logic       out_last_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_digit_select_i)
      && $stable(out_segments_i) && $stable(out_last_i))
    else $error("stalled result changed");

  // a display request blocks the next transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_req_type_i != REQ_TICK) |=> !in_ready_i)
    else $error("request taken during conversion");

  // no new request while the scan is unfinished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("ready before final result");

  // hidden results are blank
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_digit_select_i == SEL_NONE) |-> out_segments_i == SEG_BLANK)
    else $error("lit segments with no digit");

  // point-only result sits on the middle digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_segments_i == SEG_POINT) |->
      (out_digit_select_i == 3'd2) || (out_digit_select_i == 3'd5))
    else $error("decimal point on wrong digit");

endmodule

bind seven_segment_value_scanner_top ssvs_checker u_ssvs_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .in_req_type_i      (in_i.req_type),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_digit_select_i (out_o.digit_select),
  .out_segments_i     (out_o.segments),
  .out_last_i         (out_o.last)
);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of seven_segment_value_scanner_top. Requests are
// driven directed and then at random, with random gaps and receiver stalls.
// A scoreboard class tracks the blink flag and the digits last shown, works
// out the scan results of every accepted request and compares each received
// scan result with the oldest one expected.
// ----------------------------------------------------------------------------
module tb;
  import ssvs_pkg::*;

  localparam int unsigned ShowLimit   = 1000;
  localparam int unsigned NumRandom   = 250;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned DrainCycles = 40;

  typedef struct packed {
    logic [SelW-1:0] digit_select;
    logic [SegW-1:0] segments;
    logic            last;
  } scan_t;

  class scan_scoreboard;
    bit          blink_on;
    logic [11:0] int_digits;
    bit          int_shown;
    scan_t       pending_scans[$];
    int unsigned n_errors;

    function new();
      blink_on   = 1'b0;
      int_digits = '0;
      int_shown  = 1'b0;
      n_errors   = 0;
    endfunction

    function logic [SegW-1:0] glyph(int unsigned d);
      logic [SegW-1:0] pattern;
      case (d % 10)
        0:       pattern = 8'h3F;
        1:       pattern = 8'h06;
        2:       pattern = 8'h5B;
        3:       pattern = 8'h4F;
        4:       pattern = 8'h66;
        5:       pattern = 8'h6D;
        6:       pattern = 8'h7D;
        7:       pattern = 8'h07;
        8:       pattern = 8'h7F;
        default: pattern = 8'h6F;
      endcase
      return pattern;
    endfunction

    // expected scan results of one accepted request
    function void note_request(logic [1:0] kind, logic right, logic [15:0] value);
      scan_t           scans[$];
      logic [SelW-1:0] base;
      int unsigned     v;
      base = right ? RIGHT_BASE : LEFT_BASE;
      v = value;
      if (kind == REQ_TICK) begin
        blink_on = !blink_on;
      end else if (kind == REQ_INT) begin
        if (v < ShowLimit) begin
          int_digits = {4'(v / 100 % 10), 4'(v / 10 % 10), 4'(v % 10)};
          int_shown  = 1'b1;
        end
        if (int_shown) begin
          scans.push_back('{base, glyph(int_digits[11:8]), 1'b0});
          scans.push_back('{base + 3'd1, glyph(int_digits[7:4]), 1'b0});
          scans.push_back('{base + 3'd2, glyph(int_digits[3:0]), 1'b0});
        end
      end else begin
        if (v < ShowLimit) begin
          scans.push_back('{base, glyph(v / 100), 1'b0});
          scans.push_back('{base + 3'd1, glyph(v / 10), 1'b0});
          scans.push_back('{base + 3'd1, SEG_POINT, 1'b0});
          scans.push_back('{base + 3'd2, glyph(v), 1'b0});
        end else begin
          scans.push_back('{base, glyph(v / 1000), 1'b0});
          scans.push_back('{base + 3'd1, glyph(v / 100), 1'b0});
          scans.push_back('{base + 3'd2, glyph(v / 10), 1'b0});
        end
        if (kind == REQ_FIX_BLINK && !blink_on) begin
          foreach (scans[k]) scans[k] = '{SEL_NONE, SEG_BLANK, 1'b0};
        end
      end
      if (scans.size() != 0) begin
        scans[scans.size() - 1].last = 1'b1;
        foreach (scans[k]) pending_scans.push_back(scans[k]);
      end
    endfunction

    task report_mismatch(string msg);
      $display("%0t mismatch: %s", $time, msg);
      n_errors++;
    endtask

    task check_result(scan_t got);
      scan_t want;
      if (pending_scans.size() == 0) begin
        report_mismatch($sformatf("unexpected scan result sel %0d seg %02h last %0b",
                                  got.digit_select, got.segments, got.last));
      end else begin
        want = pending_scans.pop_front();
        if (got.digit_select !== want.digit_select)
          report_mismatch($sformatf("digit_select %0d, want %0d",
                                    got.digit_select, want.digit_select));
        if (got.segments !== want.segments)
          report_mismatch($sformatf("segments %02h, want %02h", got.segments, want.segments));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   steady;
  bit   hold_results;

  scan_scoreboard sb = new();

  ssvs_req_if req_if ();
  ssvs_res_if res_if ();

  seven_segment_value_scanner_top i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  always #5 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [1:0] random_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return REQ_TICK;
    if (r < 45) return REQ_INT;
    if (r < 75) return REQ_FIX;
    return REQ_FIX_BLINK;
  endfunction

  function automatic logic [15:0] random_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 16'($urandom_range(0, ShowLimit - 1));
    if (r < 70) return 16'($urandom_range(ShowLimit, 9999));
    if (r < 90) return 16'($urandom);
    if (r < 93) return 16'(ShowLimit - 1);
    if (r < 96) return 16'(ShowLimit);
    return (r < 98) ? 16'h0000 : 16'hFFFF;
  endfunction

  task automatic send_request(logic [1:0] kind, logic right, logic [15:0] value);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= kind;
    req_if.right_side <= right;
    req_if.value      <= value;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    sb.note_request(kind, right, value);
  endtask

  initial begin : result_sink
    int unsigned stall;
    scan_t       got;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_results) begin
        // long receiver stall so the block backs up into its input
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_results = 1'b0;
      end else begin
        stall = pick_gap();
        if (stall != 0) begin
          res_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      if (res_if.valid === 1'b1) begin
        got = '{res_if.digit_select, res_if.segments, res_if.last};
        sb.check_result(got);
      end
    end
  end

  initial begin : stimulus
    rst_n             <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.req_type   <= REQ_TICK;
    req_if.right_side <= 1'b0;
    req_if.value      <= '0;
    res_if.ready      <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // repeat request before any integer shown
    send_request(REQ_INT, 1'b0, 16'd1000);
    // blinking while hidden, both lengths
    send_request(REQ_FIX_BLINK, 1'b0, 16'd123);
    send_request(REQ_FIX_BLINK, 1'b1, 16'd4567);
    send_request(REQ_TICK, 1'b0, 16'd0);
    send_request(REQ_FIX_BLINK, 1'b1, 16'd987);
    send_request(REQ_FIX_BLINK, 1'b0, 16'd1000);
    send_request(REQ_INT, 1'b0, 16'd0);
    send_request(REQ_INT, 1'b1, 16'd999);
    send_request(REQ_INT, 1'b1, 16'hFFFF);
    send_request(REQ_INT, 1'b0, 16'd1000);
    send_request(REQ_FIX, 1'b0, 16'd0);
    send_request(REQ_FIX, 1'b1, 16'd999);
    send_request(REQ_FIX, 1'b0, 16'd1000);
    send_request(REQ_FIX, 1'b1, 16'hFFFF);
    send_request(REQ_INT, 1'b0, 16'd507);
    send_request(REQ_TICK, 1'b1, 16'hFFFF);
    send_request(REQ_FIX_BLINK, 1'b0, 16'd5);
    send_request(REQ_FIX_BLINK, 1'b1, 16'hFFFF);
    send_request(REQ_INT, 1'b1, 16'd42);

    for (int unsigned n = 0; n < NumRandom; n++) begin
      steady = (n >= 100 && n < 140);
      if (n == 180) hold_results = 1'b1;
      send_request(random_kind(), 1'($urandom_range(0, 1)), random_value());
    end
    steady = 1'b0;
    req_if.valid <= 1'b0;

    while (sb.pending_scans.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
